// ===== hdl/erfinv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfinv_pkg: constants for the inverse error function pipeline
// Polynomial coefficients held in Q.56, the ln2 constant and stage indices.
// ----------------------------------------------------------------------------
package erfinv_pkg;

   // ln(2) in Q0.60, split into two 30-bit halves for the log scaling stage
   localparam logic [59:0] LN2_Q60 = 60'h0B17217F7D1CF79B;
   localparam logic [29:0] LN2_HI  = LN2_Q60[59:30];
   localparam logic [29:0] LN2_LO  = LN2_Q60[29:0];

   // 6.125 in Q.28: above this magnitude of t the far polynomial is used
   localparam logic [32:0] THRESH_Q28 = 33'd1644167168;

   localparam int unsigned NUM_SQUARINGS = 30;
   localparam int unsigned NUM_HORNER    = 9;

   // Stage indices along the pipeline
   localparam int unsigned ST_NORM   = 3;
   localparam int unsigned ST_LNMUL  = ST_NORM + NUM_SQUARINGS + 1;
   localparam int unsigned ST_T      = ST_LNMUL + 1;
   localparam int unsigned ST_FMUL   = ST_T + 2 * NUM_HORNER + 1;
   localparam int unsigned ST_FSUM   = ST_FMUL + 1;
   localparam int unsigned ST_OUT    = ST_FSUM + 1;

   // Coefficient k of the selected polynomial in Q.56. The far polynomial is
   // led by a zero so that both run through the same nine Horner steps.
   function automatic logic signed [63:0] coef(input logic far, input logic [3:0] k);
      logic signed [63:0] c;
      c = '0;
      if (far) begin
         case (k)
            4'd1:    c = 64'sh14DEB44;
            4'd2:    c = 64'sh1F7C9AE << 6;
            4'd3:    c = 64'sh147E512 << 12;
            4'd4:    c = 64'sh1DCA7DE << 16;
            4'd5:    c = 64'sh19CAB92 << 20;
            4'd6:    c = 64'sh18CC0DE << 23;
            4'd7:    c = 64'sh13CA920 << 24;
            4'd8:    c = -(64'sh10EFF66 << 30);
            4'd9:    c = 64'sh1AE16A4 << 31;
            default: c = '0;
         endcase
      end else begin
         case (k)
            4'd0:    c = 64'sh175C000 << 4;
            4'd1:    c = 64'sh133B402 << 9;
            4'd2:    c = 64'sh1499232 << 12;
            4'd3:    c = 64'sh1E52CD2 << 8;
            4'd4:    c = -(64'sh1D70BD0 << 17);
            4'd5:    c = -(64'sh135BE90 << 19);
            4'd6:    c = 64'sh12F6400 << 23;
            4'd7:    c = 64'sh17A1E50 << 25;
            4'd8:    c = -(64'sh1DB2AEE << 29);
            4'd9:    c = 64'sh1C5BF88 << 31;
            default: c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== hdl/inverse_error_function.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function: pipelined erfinv, Q0.31 in, Q3.28 out
// Forms 1 - a*a, a squaring logarithm, a Horner polynomial and the final a*p.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | req_argument (s32, Q0.31)
//  rsp_     | out       | rsp_valid/rsp_ready  | rsp_result_value (s32, Q3.28),
//           |           |                      | rsp_saturated
//
//  One transaction enters every cycle unless held; depth is set by the thirty
//  32x32 squaring stages of the logarithm and the two-stage Horner steps.
//  The whole pipeline advances together; it holds while the output register
//  is full and rsp_ready is low, and nothing is lost or repeated.
//  Synchronous active-high reset clears the valid bits only.
// ----------------------------------------------------------------------------
module inverse_error_function (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_argument,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_saturated
);

   localparam int unsigned NSQ = erfinv_pkg::NUM_SQUARINGS;
   localparam int unsigned NH  = erfinv_pkg::NUM_HORNER;
   localparam int unsigned OUT = erfinv_pkg::ST_OUT;

   logic en;

   // Valid, argument and flag shift lines
   logic               v_ff [0:OUT];
   logic signed [31:0] a_ff [0:erfinv_pkg::ST_FMUL-1];
   logic               s_ff [0:erfinv_pkg::ST_FSUM];

   // Front end
   logic [62:0] sq_ff;
   logic [62:0] w_ff;

   // Logarithm
   logic [31:0] m_ff [0:NSQ];
   logic [29:0] f_ff [0:NSQ];
   logic [5:0]  e_ff [0:NSQ];
   logic [64:0] lnhi_ff, lnlo_ff;

   // Horner
   logic signed [63:0] p_ff   [0:NH];
   logic [32:0]        t_ff   [0:NH];
   logic               far_ff [0:NH];
   logic [64:0]        hlo_ff [1:NH];
   logic [64:0]        hhi_ff [1:NH];
   logic               hng_ff [1:NH];
   logic [32:0]        ta_ff  [1:NH];
   logic               fa_ff  [1:NH];

   // Final product
   logic [63:0]        flo_ff, fhi_ff;
   logic               fng_ff;
   logic signed [38:0] r_ff;
   logic signed [31:0] res_ff;

   assign en        = !v_ff[OUT] || rsp_ready;
   assign req_ready = en;

   // ---------------- valid and side-band shift lines ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= OUT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i <= OUT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= req_argument;
         s_ff[0] <= (req_argument == 32'sh80000000);
         for (int i = 1; i < erfinv_pkg::ST_FMUL; i++) a_ff[i] <= a_ff[i-1];
         for (int i = 1; i <= erfinv_pkg::ST_FSUM; i++) s_ff[i] <= s_ff[i-1];
      end
   end

   // ---------------- w = 1 - a*a in Q0.62 ----------------
   logic [31:0] ua_in;
   logic [63:0] sq_in;
   logic [62:0] w_in;
   assign ua_in = a_ff[0][31] ? 32'(-a_ff[0]) : 32'(a_ff[0]);
   assign sq_in = 64'(ua_in) * 64'(ua_in);
   assign w_in  = (63'd1 << 62) - sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in[62:0];
         w_ff  <= w_in;
      end
   end

   // ---------------- normalisation: mantissa in [2^31, 2^32) ----------------
   logic [5:0]  e_in;
   logic [5:0]  sh_in;
   logic [62:0] wsh_in;
   always_comb begin
      e_in = '0;
      for (int i = 0; i < 63; i++) begin
         if (w_ff[i]) e_in = 6'(i);
      end
      sh_in  = (e_in >= 6'd31) ? e_in - 6'd31 : 6'd0;
      wsh_in = w_ff >> sh_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= wsh_in[31:0];
         e_ff[0] <= e_in;
         f_ff[0] <= '0;
      end
   end

   // ---------------- squaring stages: one fraction bit each ----------------
   for (genvar gi = 0; gi < NSQ; gi++) begin : g_sq
      logic [63:0] prod_in;
      logic [32:0] q_in;
      assign prod_in = 64'(m_ff[gi]) * 64'(m_ff[gi]);
      assign q_in    = prod_in[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[gi+1] <= q_in[32] ? q_in[32:1] : q_in[31:0];
            f_ff[gi+1] <= f_ff[gi] | (q_in[32] ? (30'd1 << (NSQ - 1 - gi)) : 30'd0);
            e_ff[gi+1] <= e_ff[gi];
         end
      end
   end

   // ---------------- t = L * ln2, magnitude only since L <= 0 ----------------
   logic [34:0] absl_in;
   logic [95:0] tsum_in;
   logic [32:0] tmag_in;
   assign absl_in = {5'(6'd62 - e_ff[NSQ]), 30'd0} - 35'(f_ff[NSQ]);
   assign tsum_in = {1'b0, lnhi_ff, 30'd0} + 96'(lnlo_ff) + (96'd1 << 61);
   assign tmag_in = tsum_in[94:62];

   always_ff @(posedge clock) begin
      if (en) begin
         lnhi_ff   <= 65'(absl_in) * 65'(erfinv_pkg::LN2_HI);
         lnlo_ff   <= 65'(absl_in) * 65'(erfinv_pkg::LN2_LO);
         t_ff[0]   <= tmag_in;
         far_ff[0] <= tmag_in > erfinv_pkg::THRESH_Q28;
         p_ff[0]   <= erfinv_pkg::coef(tmag_in > erfinv_pkg::THRESH_Q28, 4'd0);
      end
   end

   // ---------------- Horner steps: partial products, then round and add ------
   // t is never positive, so the product sign is the opposite of the sign of p.
   for (genvar gk = 1; gk <= NH; gk++) begin : g_hn
      logic [63:0] up_in;
      logic [97:0] full_in;
      logic        sat_in;
      logic [63:0] mag_in;
      logic signed [63:0] sv_in;
      assign up_in   = p_ff[gk-1][63] ? 64'(-p_ff[gk-1]) : 64'(p_ff[gk-1]);
      assign full_in = {1'b0, hhi_ff[gk], 32'd0} + 98'(hlo_ff[gk]) + (98'd1 << 27);
      assign sat_in  = |full_in[97:91];
      assign mag_in  = sat_in ? 64'h7FFFFFFFFFFFFFFF : {1'b0, full_in[90:28]};
      assign sv_in   = hng_ff[gk] ? -$signed(mag_in) : $signed(mag_in);
      always_ff @(posedge clock) begin
         if (en) begin
            hlo_ff[gk] <= 65'(up_in[31:0]) * 65'(t_ff[gk-1]);
            hhi_ff[gk] <= 65'(up_in[63:32]) * 65'(t_ff[gk-1]);
            hng_ff[gk] <= ~p_ff[gk-1][63];
            ta_ff[gk]  <= t_ff[gk-1];
            fa_ff[gk]  <= far_ff[gk-1];
            p_ff[gk]   <= sv_in + erfinv_pkg::coef(fa_ff[gk], 4'(gk));
            t_ff[gk]   <= ta_ff[gk];
            far_ff[gk] <= fa_ff[gk];
         end
      end
   end

   // ---------------- result a*p to Q3.28 and clamp ----------------
   logic [63:0]        fup_in;
   logic [31:0]        fua_in;
   logic [96:0]        ffull_in;
   logic [37:0]        fmag_in;
   logic signed [38:0] r_in;
   logic signed [31:0] res_in;
   assign fup_in   = p_ff[NH][63] ? 64'(-p_ff[NH]) : 64'(p_ff[NH]);
   assign fua_in   = a_ff[erfinv_pkg::ST_FMUL-1][31] ?
                     32'(-a_ff[erfinv_pkg::ST_FMUL-1]) : 32'(a_ff[erfinv_pkg::ST_FMUL-1]);
   assign ffull_in = {1'b0, fhi_ff, 32'd0} + 97'(flo_ff) + (97'd1 << 58);
   assign fmag_in  = ffull_in[96:59];
   assign r_in     = fng_ff ? -$signed({1'b0, fmag_in}) : $signed({1'b0, fmag_in});

   always_comb begin
      if (s_ff[erfinv_pkg::ST_FSUM]) begin
         res_in = 32'sh80000000;
      end else if (r_ff > 39'sh007FFFFFFF) begin
         res_in = 32'sh7FFFFFFF;
      end else if (r_ff < -39'sh0080000000) begin
         res_in = 32'sh80000000;
      end else begin
         res_in = r_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flo_ff <= 64'(fup_in[31:0]) * 64'(fua_in);
         fhi_ff <= 64'(fup_in[63:32]) * 64'(fua_in);
         fng_ff <= p_ff[NH][63] ^ a_ff[erfinv_pkg::ST_FMUL-1][31];
         r_ff   <= r_in;
         res_ff <= res_in;
      end
   end

   logic sat_out_ff;
   always_ff @(posedge clock) begin
      if (en) sat_out_ff <= s_ff[erfinv_pkg::ST_FSUM];
   end

   assign rsp_valid        = v_ff[OUT];
   assign rsp_result_value = res_ff;
   assign rsp_saturated    = sat_out_ff;

   // ---------------- assertions ----------------
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_result_value == 32'sh80000000)
      else $error("saturated transaction without clamped result");

   a_minus_one_flag: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_argument == 32'sh80000000 |=> s_ff[0])
      else $error("exact -1 argument not flagged");

   a_norm_mant: assert property (@(posedge clock) disable iff (reset)
      v_ff[erfinv_pkg::ST_NORM] && !s_ff[erfinv_pkg::ST_NORM] |-> m_ff[0][31])
      else $error("mantissa not normalised");

   a_sq_mant: assert property (@(posedge clock) disable iff (reset)
      v_ff[erfinv_pkg::ST_NORM+1] && !s_ff[erfinv_pkg::ST_NORM+1] |-> m_ff[1][31])
      else $error("squaring stage left mantissa out of range");

endmodule

// ===== tb/inverse_error_function_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function_test: self-checking bench for the erfinv pipeline
// Drives Q0.31 arguments with random gaps and back-pressure. A bit-exact
// model of the fixed-point logarithm and Horner evaluation predicts every
// transaction, and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module inverse_error_function_test;

   localparam int LATENCY     = 56;
   localparam int STALL_LIMIT = 3000;
   localparam logic signed [31:0] MOST_NEG = 32'sh80000000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFFFFFF;
   // Arguments whose logarithm sits close to -6.125, where the polynomial changes.
   localparam logic signed [31:0] KNEE_ARG = 32'sd2145134000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sat;
   } erfinv_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_argument = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_saturated;

   erfinv_result_type pending_results[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  gaps_on = 1'b1;
   int  hold_off = 0;

   inverse_error_function DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_argument(req_argument),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_saturated(rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // round(x*y / 2^n), halves away from zero, magnitude saturated to 64 bits
   function automatic logic signed [63:0] round_mul(input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    input int n);
      logic [63:0]  ux, uy;
      logic [127:0] prod, scaled;
      logic         neg;
      neg = x[63] ^ y[63];
      ux = x[63] ? -x : x;
      uy = y[63] ? -y : y;
      prod = {64'd0, ux} * {64'd0, uy};
      scaled = (prod + (128'd1 << (n - 1))) >> n;
      if (scaled > 128'h7FFFFFFFFFFFFFFF) scaled = 128'h7FFFFFFFFFFFFFFF;
      return neg ? -$signed(scaled[63:0]) : $signed(scaled[63:0]);
   endfunction

   // Natural log of w * 2^-62 in Q.28 by repeated squaring of the mantissa.
   function automatic logic signed [63:0] log_q28(input logic [62:0] w);
      int          e;
      logic [63:0] m;
      logic [29:0] f;
      logic signed [63:0] l;
      e = 62;
      while (e > 0 && !w[e]) e--;
      m = {1'b0, w} >> (e - 31);
      f = '0;
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         if (m >= 64'h100000000) begin
            m = m >> 1;
            f[29 - i] = 1'b1;
         end
      end
      l = 64'(longint'(e - 62) * 64'sd1073741824) + $signed({34'd0, f});
      return round_mul(l, $signed({4'd0, erfinv_pkg::LN2_Q60}), 62);
   endfunction

   function automatic logic signed [63:0] far_term(input int k);
      case (k)
         0: return 64'sh14DEB44;
         1: return 64'sh1F7C9AE <<< 6;
         2: return 64'sh147E512 <<< 12;
         3: return 64'sh1DCA7DE <<< 16;
         4: return 64'sh19CAB92 <<< 20;
         5: return 64'sh18CC0DE <<< 23;
         6: return 64'sh13CA920 <<< 24;
         7: return -(64'sh10EFF66 <<< 30);
         default: return 64'sh1AE16A4 <<< 31;
      endcase
   endfunction

   function automatic logic signed [63:0] near_term(input int k);
      case (k)
         0: return 64'sh175C000 <<< 4;
         1: return 64'sh133B402 <<< 9;
         2: return 64'sh1499232 <<< 12;
         3: return 64'sh1E52CD2 <<< 8;
         4: return -(64'sh1D70BD0 <<< 17);
         5: return -(64'sh135BE90 <<< 19);
         6: return 64'sh12F6400 <<< 23;
         7: return 64'sh17A1E50 <<< 25;
         8: return -(64'sh1DB2AEE <<< 29);
         default: return 64'sh1C5BF88 <<< 31;
      endcase
   endfunction

   function automatic erfinv_result_type predict_erfinv(input logic signed [31:0] arg);
      erfinv_result_type  res;
      logic [31:0]        mag;
      logic [62:0]        w;
      logic signed [63:0] t, p, r;
      if (arg == MOST_NEG) begin
         res.value = MOST_NEG;
         res.sat = 1'b1;
         return res;
      end
      mag = arg[31] ? -arg : arg;
      w = (63'd1 << 62) - {31'd0, mag} * {31'd0, mag};
      t = log_q28(w);
      if (t < -$signed({31'd0, erfinv_pkg::THRESH_Q28})) begin
         p = far_term(0);
         for (int i = 1; i < 9; i++) p = round_mul(p, t, 28) + far_term(i);
      end else begin
         p = near_term(0);
         for (int i = 1; i < 10; i++) p = round_mul(p, t, 28) + near_term(i);
      end
      r = round_mul(64'(arg), p, 59);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.value = r[31:0];
      res.sat = 1'b0;
      return res;
   endfunction

   function automatic int pick_gap();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Offers one argument; valid stays high back to back when no gap is drawn.
   task automatic send_argument(input logic signed [31:0] arg);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_argument = arg;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_erfinv(arg));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready = 1'b0;
         hold_off--;
      end else if (gaps_on && $urandom_range(0, 9) < 3) begin
         rsp_ready = 1'b0;
         hold_off = pick_gap();
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      erfinv_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("unexpected transaction on rsp at %0t", $realtime);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_value !== want.value)
               report_mismatch("result_value", rsp_result_value, want.value);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", rsp_saturated, want.sat);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("inverse_error_function test failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] random_argument();
      logic signed [31:0] a;
      case ($urandom_range(0, 9))
         0, 1, 2: a = $urandom;
         3: a = MOST_POS - $signed($urandom_range(0, 1 << $urandom_range(0, 24)));
         4: a = MOST_NEG + 1 + $signed($urandom_range(0, 1 << $urandom_range(0, 24)));
         5: a = KNEE_ARG + $signed($urandom_range(0, 1 << 18)) - (1 <<< 17);
         6: a = $signed($urandom) >>> $urandom_range(0, 31);
         7: a = ($urandom_range(0, 3) == 0) ? MOST_NEG : $urandom;
         default: a = $urandom;
      endcase
      if (a[31] == 1'b0 && $urandom_range(0, 1) && a != 0 && a != MOST_POS &&
          (a >= KNEE_ARG - 32'sd200000 && a <= KNEE_ARG + 32'sd200000))
         a = -a;
      return a;
   endfunction

   task automatic test_edge_arguments();
      logic signed [31:0] picks[$];
      picks = '{32'sd0, 32'sd1, -32'sd1, MOST_POS, MOST_NEG, MOST_NEG + 1,
                32'sh40000000, -32'sh40000000, KNEE_ARG, -KNEE_ARG, KNEE_ARG - 1,
                KNEE_ARG + 1, MOST_POS - 1, 32'sh55555555, 32'shAAAAAAAA,
                32'sh7FFF0000, MOST_NEG, 32'sd1000};
      gaps_on = 1'b0;
      foreach (picks[i]) send_argument(picks[i]);
      gaps_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_arguments(input int count);
      for (int i = 0; i < count; i++) begin
         gaps_on = (i % 100) >= 20;   // a stretch without idling in every hundred
         send_argument(random_argument());
      end
      gaps_on = 1'b1;
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall req.
   task automatic test_back_pressure();
      gaps_on = 1'b0;
      hold_off = 250;
      for (int i = 0; i < 120; i++) send_argument(random_argument());
      gaps_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_edge_arguments();
      test_random_arguments(200);
      test_back_pressure();
      test_random_arguments(230);
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("inverse_error_function test passed");
      else
         $display("inverse_error_function test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/erfinv_pkg.sv
hdl/inverse_error_function.sv
tb/inverse_error_function_test.sv
